### sv/nearest_target_standoff_point_top_assert.svh
// Assertion macros for the nearest target standoff point block.
// Used by the top level only; expects clk and rst_n in scope.
`ifndef NEAREST_TARGET_STANDOFF_POINT_TOP_ASSERT_SVH
`define NEAREST_TARGET_STANDOFF_POINT_TOP_ASSERT_SVH

// Same-cycle implication, masked while reset is applied
`define NTSP_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, masked while reset is applied
`define NTSP_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/ntsp_pkg.sv
// Shared types, constants and the CORDIC arctangent table for the
// nearest target standoff point block. No dependencies.
`default_nettype none

package ntsp_pkg;

  // Fixed field widths
  localparam int COORD_W   = 31;
  localparam int DIFF_W    = 32;
  localparam int RADIUS_W  = 24;
  localparam int YAW_W     = 17;
  localparam int QUAT_W    = 16;

  // CORDIC datapath widths: vectors in 36 bits, angles in 2^-16 rad over 20 bits
  localparam int XY_W      = 36;
  localparam int Z_W       = 20;
  localparam int TAB_LEN   = 24;
  localparam int TAB_IDX_W = 5;

  // Angle and scale constants
  localparam logic signed [Z_W-1:0]  ANG_PI      = 20'sd205887;
  localparam logic signed [Z_W-1:0]  ANG_HALF_PI = 20'sd102944;
  localparam logic signed [16:0]     YAW_PI      = 17'sd25736;
  localparam logic signed [XY_W-1:0] GAIN_Q30    = 36'sd652032874;
  localparam logic signed [19:0]     Q14_ONE     = 20'sd16384;

  // Control of the shared CORDIC step unit
  typedef struct packed {
    logic                 vectoring;
    logic [TAB_IDX_W-1:0] shift;
  } cordic_ctl_t;

  // atan(2^-i) in units of 2^-16 rad
  function automatic logic signed [Z_W-1:0] arc_angle(input logic [TAB_IDX_W-1:0] idx);
    logic signed [Z_W-1:0] a;
    case (idx)
      5'd0:    a = 20'sd51472;
      5'd1:    a = 20'sd30386;
      5'd2:    a = 20'sd16055;
      5'd3:    a = 20'sd8150;
      5'd4:    a = 20'sd4091;
      5'd5:    a = 20'sd2047;
      5'd6:    a = 20'sd1024;
      5'd7:    a = 20'sd512;
      5'd8:    a = 20'sd256;
      5'd9:    a = 20'sd128;
      5'd10:   a = 20'sd64;
      5'd11:   a = 20'sd32;
      5'd12:   a = 20'sd16;
      5'd13:   a = 20'sd8;
      5'd14:   a = 20'sd4;
      5'd15:   a = 20'sd2;
      5'd16:   a = 20'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

### sv/nearest_target_standoff_point_top.sv
// Nearest target standoff point. Each obstacle transaction runs an accept, then
// two passes through the shared 32x32 multiplier (dx^2, dy^2) and a 64-bit compare.
// The closing transaction of a frame then runs three N-step passes (N = CORDIC_STEPS,
// at most 24) through the single CORDIC step unit (atan2, cos/sin of theta, cos/sin
// of yaw/2) plus two multiplier passes for the standoff offset. An empty-frame
// transaction goes straight to the result when no centre is kept; when it closes a
// frame that holds one, it runs the same frame-end sequence after its accept. The input
// is not ready while a transaction is worked on; a result waits in the output register
// while the next frame streams in.
// Depends on ntsp_pkg, ntsp_cordic_step and nearest_target_standoff_point_top_assert.svh.
`default_nettype none

module nearest_target_standoff_point_top #(
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  // config: standoff radius, unsigned Q8.16 m
  input  wire logic         cfg_wr_en,
  input  wire logic [23:0]  cfg_wr_data,
  // input tdata, low bit up: obstacle_x[30:0], obstacle_y[61:31], robot_x[92:62],
  // robot_y[123:93], zero fill [127:124]
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,
  input  wire logic         in_tlast,   // last_in_frame
  input  wire logic         in_tuser,   // empty_frame
  // output tdata, low bit up: target_x[31:0], target_y[63:32], yaw[80:64],
  // quat_z[96:81], quat_w[112:97], zero fill [119:113]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [119:0]      out_tdata,
  output logic              out_tuser   // found
);

  localparam int N_STEPS = (CORDIC_STEPS > ntsp_pkg::TAB_LEN) ? ntsp_pkg::TAB_LEN
                                                              : CORDIC_STEPS;
  localparam logic [ntsp_pkg::TAB_IDX_W-1:0] LAST_STEP = ntsp_pkg::TAB_IDX_W'(N_STEPS - 1);

  typedef enum logic [3:0] {
    S_IDLE, S_MUL_X, S_MUL_Y, S_CMP, S_END, S_VEC, S_THETA, S_ROT1,
    S_TC, S_MC, S_MS, S_TY, S_ROT2, S_Q, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic [ntsp_pkg::TAB_IDX_W-1:0] cnt_r, cnt_nxt;

  logic [ntsp_pkg::RADIUS_W-1:0] radius_r, radius_nxt;

  logic signed [ntsp_pkg::COORD_W-1:0] ox_r, ox_nxt, oy_r, oy_nxt;
  logic signed [ntsp_pkg::COORD_W-1:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic last_r, last_nxt;
  logic signed [ntsp_pkg::DIFF_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt;

  logic signed [63:0] prod_r, prod_nxt;
  logic [63:0] acc_r, acc_nxt;

  logic signed [ntsp_pkg::COORD_W-1:0] best_x_r, best_x_nxt, best_y_r, best_y_nxt;
  logic [63:0] best_d_r, best_d_nxt;
  logic have_best_r, have_best_nxt;

  logic signed [ntsp_pkg::XY_W-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [ntsp_pkg::Z_W-1:0]  cz_r, cz_nxt;
  logic neg_r, neg_nxt;

  logic signed [31:0] c_r, c_nxt, s_r, s_nxt;
  logic signed [16:0] yaw_r, yaw_nxt;
  logic signed [31:0] tx_r, tx_nxt, ty_r, ty_nxt;
  logic signed [15:0] qz_r, qz_nxt, qw_r, qw_nxt;

  logic         out_tvalid_r, out_tvalid_nxt;
  logic [119:0] out_tdata_r, out_tdata_nxt;
  logic         out_tuser_r, out_tuser_nxt;

  // Shared multiplier operands
  logic signed [31:0] mul_a, mul_b;

  // Shared CORDIC step unit
  ntsp_pkg::cordic_ctl_t cctl;
  logic signed [ntsp_pkg::XY_W-1:0] cx_step, cy_step;
  logic signed [ntsp_pkg::Z_W-1:0]  cz_step;

  assign cctl.vectoring = (state_r == S_VEC);
  assign cctl.shift     = cnt_r;

  ntsp_cordic_step u_cordic (
    .ctl   (cctl),
    .x_in  (cx_r),
    .y_in  (cy_r),
    .z_in  (cz_r),
    .x_out (cx_step),
    .y_out (cy_step),
    .z_out (cz_step)
  );

  // Input field views
  logic signed [ntsp_pkg::COORD_W-1:0] in_ox, in_oy, in_rx, in_ry;
  assign in_ox = in_tdata[30:0];
  assign in_oy = in_tdata[61:31];
  assign in_rx = in_tdata[92:62];
  assign in_ry = in_tdata[123:93];

  // Frame-end vector from the robot to the kept centre
  logic signed [ntsp_pkg::DIFF_W-1:0] bdx, bdy;
  logic signed [ntsp_pkg::XY_W-1:0]   vx0, vy0;
  assign bdx = {best_x_r[30], best_x_r} - {rx_r[30], rx_r};
  assign bdy = {best_y_r[30], best_y_r} - {ry_r[30], ry_r};
  assign vx0 = {{4{bdx[31]}}, bdx};
  assign vy0 = {{4{bdy[31]}}, bdy};

  // Round the CORDIC angle to Q3.13 and clamp to +-pi
  logic signed [ntsp_pkg::Z_W-1:0] z_rnd;
  logic signed [16:0]              theta_raw, theta;
  assign z_rnd     = cz_r + 20'sd4;
  assign theta_raw = z_rnd[19:3];
  always_comb begin
    if (theta_raw > ntsp_pkg::YAW_PI) begin
      theta = ntsp_pkg::YAW_PI;
    end else if (theta_raw < -ntsp_pkg::YAW_PI) begin
      theta = -ntsp_pkg::YAW_PI;
    end else begin
      theta = theta_raw;
    end
  end

  // Rotation start angle: theta*8 or yaw*4, folded into +-pi/2
  logic signed [ntsp_pkg::Z_W-1:0] rot_a, rot_red;
  logic                            rot_neg;
  assign rot_a = (state_r == S_THETA) ? {theta, 3'b000} : {yaw_r[16], yaw_r, 2'b00};
  always_comb begin
    if (rot_a > ntsp_pkg::ANG_HALF_PI) begin
      rot_red = rot_a - ntsp_pkg::ANG_PI;
      rot_neg = 1'b1;
    end else if (rot_a < -ntsp_pkg::ANG_HALF_PI) begin
      rot_red = rot_a + ntsp_pkg::ANG_PI;
      rot_neg = 1'b1;
    end else begin
      rot_red = rot_a;
      rot_neg = 1'b0;
    end
  end

  // Round radius*trig product from Q2.30 scale back to Q16.16
  logic signed [63:0] prod_rnd;
  assign prod_rnd = prod_r + 64'sd536870912;

  // Half-angle results to Q1.14 with clamp
  logic signed [ntsp_pkg::XY_W-1:0] hs, hc, hs_rnd, hc_rnd;
  logic signed [19:0] hs_q, hc_q;
  assign hs     = neg_r ? -cy_r : cy_r;
  assign hc     = neg_r ? -cx_r : cx_r;
  assign hs_rnd = hs + 36'sd32768;
  assign hc_rnd = hc + 36'sd32768;
  always_comb begin
    hs_q = hs_rnd[35:16];
    hc_q = hc_rnd[35:16];
    if (hs_q > ntsp_pkg::Q14_ONE) hs_q = ntsp_pkg::Q14_ONE;
    if (hs_q < -ntsp_pkg::Q14_ONE) hs_q = -ntsp_pkg::Q14_ONE;
    if (hc_q > ntsp_pkg::Q14_ONE) hc_q = ntsp_pkg::Q14_ONE;
    if (hc_q < -ntsp_pkg::Q14_ONE) hc_q = -ntsp_pkg::Q14_ONE;
  end

  // Cos/sin of theta - pi: negate unless the fold already negated
  logic signed [ntsp_pkg::XY_W-1:0] c_full, s_full;
  assign c_full = neg_r ? cx_r : -cx_r;
  assign s_full = neg_r ? cy_r : -cy_r;

  logic [63:0] sum_sq;
  assign sum_sq = acc_r + prod_r;

  logic out_free;
  assign out_free = !out_tvalid_r || out_tready;

  // Sequencer and datapath next state
  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    radius_nxt     = radius_r;
    ox_nxt         = ox_r;
    oy_nxt         = oy_r;
    rx_nxt         = rx_r;
    ry_nxt         = ry_r;
    last_nxt       = last_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    acc_nxt        = acc_r;
    best_x_nxt     = best_x_r;
    best_y_nxt     = best_y_r;
    best_d_nxt     = best_d_r;
    have_best_nxt  = have_best_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    cz_nxt         = cz_r;
    neg_nxt        = neg_r;
    c_nxt          = c_r;
    s_nxt          = s_r;
    yaw_nxt        = yaw_r;
    tx_nxt         = tx_r;
    ty_nxt         = ty_r;
    qz_nxt         = qz_r;
    qw_nxt         = qw_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;
    mul_a          = dx_r;
    mul_b          = dx_r;

    if (cfg_wr_en) begin
      radius_nxt = cfg_wr_data;
    end

    unique case (state_r)
      S_IDLE: begin
        // Latch a transaction and form the deltas
        if (in_tvalid) begin
          ox_nxt   = in_ox;
          oy_nxt   = in_oy;
          rx_nxt   = in_rx;
          ry_nxt   = in_ry;
          last_nxt = in_tlast;
          dx_nxt   = {in_ox[30], in_ox} - {in_rx[30], in_rx};
          dy_nxt   = {in_oy[30], in_oy} - {in_ry[30], in_ry};
          state_nxt = in_tuser ? S_END : S_MUL_X;
        end
      end
      S_MUL_X: begin
        state_nxt = S_MUL_Y;
      end
      S_MUL_Y: begin
        acc_nxt   = prod_r;
        mul_a     = dy_r;
        mul_b     = dy_r;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // Strict less-than keeps the first of equal candidates
        if (sum_sq < best_d_r) begin
          best_d_nxt    = sum_sq;
          best_x_nxt    = ox_r;
          best_y_nxt    = oy_r;
          have_best_nxt = 1'b1;
        end
        state_nxt = last_r ? S_END : S_IDLE;
      end
      S_END: begin
        // Pre-rotate into the right half plane for vectoring
        cnt_nxt = '0;
        if (!have_best_r) begin
          state_nxt = S_DONE;
        end else if (bdx == '0 && bdy == '0) begin
          cz_nxt    = '0;
          state_nxt = S_THETA;
        end else begin
          if (bdx[31]) begin
            if (!bdy[31]) begin
              cx_nxt = vy0;
              cy_nxt = -vx0;
              cz_nxt = ntsp_pkg::ANG_HALF_PI;
            end else begin
              cx_nxt = -vy0;
              cy_nxt = vx0;
              cz_nxt = -ntsp_pkg::ANG_HALF_PI;
            end
          end else begin
            cx_nxt = vx0;
            cy_nxt = vy0;
            cz_nxt = '0;
          end
          state_nxt = S_VEC;
        end
      end
      S_VEC, S_ROT1, S_ROT2: begin
        // Advance the shared CORDIC unit one step
        cx_nxt  = cx_step;
        cy_nxt  = cy_step;
        cz_nxt  = cz_step;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_STEP) begin
          cnt_nxt = '0;
          if (state_r == S_VEC) begin
            state_nxt = S_THETA;
          end else if (state_r == S_ROT1) begin
            state_nxt = S_TC;
          end else begin
            state_nxt = S_Q;
          end
        end
      end
      S_THETA: begin
        yaw_nxt   = theta - ntsp_pkg::YAW_PI;
        cx_nxt    = ntsp_pkg::GAIN_Q30;
        cy_nxt    = '0;
        cz_nxt    = rot_red;
        neg_nxt   = rot_neg;
        cnt_nxt   = '0;
        state_nxt = S_ROT1;
      end
      S_TC: begin
        c_nxt     = c_full[31:0];
        s_nxt     = s_full[31:0];
        state_nxt = S_MC;
      end
      S_MC: begin
        mul_a     = {8'b0, radius_r};
        mul_b     = c_r;
        state_nxt = S_MS;
      end
      S_MS: begin
        tx_nxt    = {best_x_r[30], best_x_r} + prod_rnd[61:30];
        mul_a     = {8'b0, radius_r};
        mul_b     = s_r;
        state_nxt = S_TY;
      end
      S_TY: begin
        ty_nxt    = {best_y_r[30], best_y_r} + prod_rnd[61:30];
        cx_nxt    = ntsp_pkg::GAIN_Q30;
        cy_nxt    = '0;
        cz_nxt    = rot_red;
        neg_nxt   = rot_neg;
        cnt_nxt   = '0;
        state_nxt = S_ROT2;
      end
      S_Q: begin
        qz_nxt    = hs_q[15:0];
        qw_nxt    = hc_q[15:0];
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Load the output register once it is free, then clear the frame
        if (out_free) begin
          out_tvalid_nxt = 1'b1;
          out_tuser_nxt  = have_best_r;
          if (have_best_r) begin
            out_tdata_nxt = {7'b0, qw_r, qz_r, yaw_r, ty_r, tx_r};
          end else begin
            out_tdata_nxt = '0;
          end
          best_x_nxt    = '0;
          best_y_nxt    = '0;
          best_d_nxt    = '1;
          have_best_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    prod_nxt = mul_a * mul_b;
  end

  // State, control and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cnt_r        <= '0;
      radius_r     <= 24'd65536;
      best_x_r     <= '0;
      best_y_r     <= '0;
      best_d_r     <= '1;
      have_best_r  <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cnt_r        <= cnt_nxt;
      radius_r     <= radius_nxt;
      best_x_r     <= best_x_nxt;
      best_y_r     <= best_y_nxt;
      best_d_r     <= best_d_nxt;
      have_best_r  <= have_best_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
    ox_r        <= ox_nxt;
    oy_r        <= oy_nxt;
    rx_r        <= rx_nxt;
    ry_r        <= ry_nxt;
    last_r      <= last_nxt;
    dx_r        <= dx_nxt;
    dy_r        <= dy_nxt;
    prod_r      <= prod_nxt;
    acc_r       <= acc_nxt;
    cx_r        <= cx_nxt;
    cy_r        <= cy_nxt;
    cz_r        <= cz_nxt;
    neg_r       <= neg_nxt;
    c_r         <= c_nxt;
    s_r         <= s_nxt;
    yaw_r       <= yaw_nxt;
    tx_r        <= tx_nxt;
    ty_r        <= ty_nxt;
    qz_r        <= qz_nxt;
    qw_r        <= qw_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  // Checks
  logic signed [16:0] out_yaw_chk;
  assign out_yaw_chk = out_tdata_r[80:64];

`include "nearest_target_standoff_point_top_assert.svh"

  `NTSP_ASSERT_IMPLIES(a_empty_result_zero, out_tvalid && !out_tuser, out_tdata == '0, "result without target carries nonzero data")
  `NTSP_ASSERT_IMPLIES(a_yaw_range, out_tvalid && out_tuser, (out_yaw_chk <= 17'sd0) && (out_yaw_chk >= -17'sd51472), "yaw out of range")
  `NTSP_ASSERT_IMPLIES(a_step_count, (state_r == S_VEC) || (state_r == S_ROT1) || (state_r == S_ROT2), cnt_r <= LAST_STEP, "CORDIC step count overran")
  `NTSP_ASSERT_NEXT(a_frame_cleared, (state_r == S_DONE) && out_free, !have_best_r && (best_d_r == '1) && out_tvalid, "frame not cleared after result")

endmodule

`default_nettype wire

### sv/ntsp_cordic_step.sv
// One CORDIC micro-rotation, shared by vectoring (atan2) and rotation (cos/sin).
// Depends on ntsp_pkg for widths, the control struct and the angle table.
`default_nettype none

module ntsp_cordic_step (
  input  var ntsp_pkg::cordic_ctl_t                ctl,
  input  wire logic signed [ntsp_pkg::XY_W-1:0]    x_in,
  input  wire logic signed [ntsp_pkg::XY_W-1:0]    y_in,
  input  wire logic signed [ntsp_pkg::Z_W-1:0]     z_in,
  output logic signed [ntsp_pkg::XY_W-1:0]         x_out,
  output logic signed [ntsp_pkg::XY_W-1:0]         y_out,
  output logic signed [ntsp_pkg::Z_W-1:0]          z_out
);

  logic signed [ntsp_pkg::XY_W-1:0] x_sh;
  logic signed [ntsp_pkg::XY_W-1:0] y_sh;
  logic signed [ntsp_pkg::Z_W-1:0]  ang;
  logic                             up;

  assign x_sh = x_in >>> ctl.shift;
  assign y_sh = y_in >>> ctl.shift;
  assign ang  = ntsp_pkg::arc_angle(ctl.shift);

  // Vectoring drives y toward zero; rotation drives the residual angle toward zero
  assign up = ctl.vectoring ? ~y_in[ntsp_pkg::XY_W-1] : z_in[ntsp_pkg::Z_W-1];

  // Rotate one step in the chosen direction
  always_comb begin
    if (up) begin
      x_out = x_in + y_sh;
      y_out = y_in - x_sh;
      z_out = z_in + ang;
    end else begin
      x_out = x_in - y_sh;
      y_out = y_in + x_sh;
      z_out = z_in - ang;
    end
  end

endmodule

`default_nettype wire

### sim/testbench.sv
// Self-checking testbench for nearest_target_standoff_point_top.
// Streams obstacle frames, predicts each standoff result in SystemVerilog and
// compares every output transaction field by field. Needs only the RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CORDIC_STEPS    = 16;
  localparam int RESET_CYCLES    = 7;
  localparam int SETTLE_CYCLES   = 80;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int PHASES          = 6;
  localparam int ITEMS_PER_PHASE = 290;

  localparam int COORD_MAX  = 1073741823;
  localparam int COORD_MIN  = -1073741824;
  localparam int RADIUS_MAX = 16777215;

  // Angles in 2^-16 rad, heading in Q3.13, trig in Q2.30
  localparam longint ARC_PI      = 205887;
  localparam longint ARC_HALF_PI = 102944;
  localparam longint HEADING_PI  = 25736;
  localparam longint CORDIC_GAIN = 652032874;
  localparam longint ROUND_Q30   = 536870912;
  localparam longint Q14_LIMIT   = 16384;

  typedef logic signed [30:0] coord_t;

  typedef struct packed {
    coord_t ox;
    coord_t oy;
    coord_t rx;
    coord_t ry;
    logic   last;
    logic   empty;
  } obstacle_t;

  typedef struct packed {
    logic               found;
    logic signed [31:0] tx;
    logic signed [31:0] ty;
    logic signed [16:0] yaw;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } standoff_t;

  typedef enum int {RX_READY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic         clk;
  logic         rst_n       = 1'b0;
  logic         cfg_wr_en   = 1'b0;
  logic [23:0]  cfg_wr_data = '0;
  logic         in_tvalid   = 1'b0;
  logic         in_tready;
  logic [127:0] in_tdata    = '0;
  logic         in_tlast    = 1'b0;
  logic         in_tuser    = 1'b0;
  logic         out_tvalid;
  logic         out_tready  = 1'b0;
  logic [119:0] out_tdata;
  logic         out_tuser;

  obstacle_t obstacle_q[$];
  standoff_t standoff_q[$];

  // Predictor state: nearest centre of the open frame and the radius in force
  logic [23:0]     radius_now = 24'd65536;
  longint          near_x     = 0;
  longint          near_y     = 0;
  longint unsigned near_dist  = '1;
  bit              have_near  = 1'b0;

  int        error_count  = 0;
  int        quiet_cycles = 0;
  int        burst_left   = 0;
  int        gap_left     = 0;
  int        stall_left   = 0;
  rx_mode_t  stall_mode   = RX_READY;
  obstacle_t next_item;
  standoff_t want;
  standoff_t seen;

  nearest_target_standoff_point_top #(
    .CORDIC_STEPS(CORDIC_STEPS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // atan(2^-i) in 2^-16 rad
  function automatic longint atan_step(input int i);
    longint a;
    case (i)
      0:       a = 51472;
      1:       a = 30386;
      2:       a = 16055;
      3:       a = 8150;
      4:       a = 4091;
      5:       a = 2047;
      6:       a = 1024;
      7:       a = 512;
      8:       a = 256;
      9:       a = 128;
      10:      a = 64;
      11:      a = 32;
      12:      a = 16;
      13:      a = 8;
      14:      a = 4;
      15:      a = 2;
      16:      a = 1;
      default: a = 0;
    endcase
    return a;
  endfunction

  // Vectoring CORDIC: atan2(y, x) in 2^-16 rad
  function automatic longint heading_of(input longint y, input longint x);
    longint z, t, xn;
    int i;
    z = 0;
    if (x == 0 && y == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = ARC_HALF_PI;
      end else begin
        t = x; x = -y; y = t; z = -ARC_HALF_PI;
      end
    end
    for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (y >= 0) begin
        xn = x + (y >>> i); y = y - (x >>> i); z += atan_step(i);
      end else begin
        xn = x - (y >>> i); y = y + (x >>> i); z -= atan_step(i);
      end
      x = xn;
    end
    return z;
  endfunction

  // Rotation CORDIC: cos and sin of ang (2^-16 rad) in Q2.30
  task automatic rotate(input longint ang, output longint cos_v, output longint sin_v);
    longint x, y, xn, a;
    bit flip;
    int i;
    a = ang;
    x = CORDIC_GAIN;
    y = 0;
    flip = 1'b0;
    if (a > ARC_HALF_PI) begin
      a -= ARC_PI; flip = 1'b1;
    end else if (a < -ARC_HALF_PI) begin
      a += ARC_PI; flip = 1'b1;
    end
    for (i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      if (a >= 0) begin
        xn = x - (y >>> i); y = y + (x >>> i); a -= atan_step(i);
      end else begin
        xn = x + (y >>> i); y = y - (x >>> i); a += atan_step(i);
      end
      x = xn;
    end
    cos_v = flip ? -x : x;
    sin_v = flip ? -y : y;
  endtask

  function automatic logic [15:0] round_q14(input longint v);
    longint r;
    r = (v + 32768) >>> 16;
    if (r > Q14_LIMIT) r = Q14_LIMIT;
    if (r < -Q14_LIMIT) r = -Q14_LIMIT;
    return r[15:0];
  endfunction

  // Fold one obstacle into the frame; on frame end queue the standoff result
  task automatic track_obstacle(input coord_t ox, input coord_t oy, input coord_t rx,
                                input coord_t ry, input bit last, input bit empty);
    longint dx, dy, theta, heading, cos_t, sin_t, cos_h, sin_h, rad, tx, ty;
    longint unsigned sum_sq;
    standoff_t res;
    if (!empty) begin
      dx = longint'(ox) - longint'(rx);
      dy = longint'(oy) - longint'(ry);
      sum_sq = dx * dx;
      sum_sq = sum_sq + dy * dy;
      // strict compare: the first of equal candidates stays
      if (sum_sq < near_dist) begin
        near_dist = sum_sq;
        near_x = longint'(ox);
        near_y = longint'(oy);
        have_near = 1'b1;
      end
    end
    if (!last && !empty) return;
    res = '0;
    if (have_near) begin
      // heading from the closing transaction's robot position
      dx = near_x - longint'(rx);
      dy = near_y - longint'(ry);
      theta = (heading_of(dy, dx) + 4) >>> 3;
      if (theta > HEADING_PI) theta = HEADING_PI;
      if (theta < -HEADING_PI) theta = -HEADING_PI;
      heading = theta - HEADING_PI;
      rotate(theta * 8, cos_t, sin_t);
      rad = longint'(radius_now);
      tx = near_x + ((rad * -cos_t + ROUND_Q30) >>> 30);
      ty = near_y + ((rad * -sin_t + ROUND_Q30) >>> 30);
      rotate(heading * 4, cos_h, sin_h);
      res.found = 1'b1;
      res.tx = tx[31:0];
      res.ty = ty[31:0];
      res.yaw = heading[16:0];
      res.qz = round_q14(sin_h);
      res.qw = round_q14(cos_h);
    end
    standoff_q.push_back(res);
    near_x = 0;
    near_y = 0;
    near_dist = '1;
    have_near = 1'b0;
  endtask

  task automatic check_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  task automatic add_item(input int ox, input int oy, input int rx, input int ry,
                          input bit last, input bit empty);
    obstacle_t it;
    it.ox = ox[30:0];
    it.oy = oy[30:0];
    it.rx = rx[30:0];
    it.ry = ry[30:0];
    it.last = last;
    it.empty = empty;
    obstacle_q.push_back(it);
  endtask

  function automatic int rand_coord();
    int r;
    r = $urandom;
    case ($urandom_range(0, 6))
      0:       r = COORD_MAX;
      1:       r = COORD_MIN;
      2:       r = 0;
      3:       r = r >>> 8;
      default: r = r >>> 1;
    endcase
    return r;
  endfunction

  function automatic int rand_offset();
    int v;
    case ($urandom_range(0, 3))
      0:       v = $urandom_range(0, 15);
      1:       v = $urandom_range(0, 655360);
      2:       v = $urandom_range(0, 65536000);
      default: v = $urandom_range(0, 268435456);
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // Queue one frame: mostly short well-formed lists, some long ones and some noise
  task automatic queue_random_frame(inout int count);
    int n, i, rx, ry, ox, oy, px, py;
    bit fixed_robot;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 16) : $urandom_range(1, 4);
    rx = rand_coord();
    ry = rand_coord();
    px = rx + rand_offset();
    py = ry + rand_offset();
    fixed_robot = ($urandom_range(0, 3) != 0);
    if ($urandom_range(0, 11) == 0) begin
      add_item(rand_coord(), rand_coord(), rx, ry, ($urandom_range(0, 1) == 1), 1'b1);
      count++;
      return;
    end
    for (i = 0; i < n; i++) begin
      if (!fixed_robot && $urandom_range(0, 1) == 1) begin
        rx = ($urandom_range(0, 3) == 0) ? rand_coord() : rx + rand_offset();
        ry = ($urandom_range(0, 3) == 0) ? rand_coord() : ry + rand_offset();
      end
      case ($urandom_range(0, 7))
        0: begin
          ox = rand_coord(); oy = rand_coord();
        end
        1: begin
          ox = px; oy = py;
        end
        2: begin
          ox = 2 * rx - px; oy = 2 * ry - py;
        end
        3: begin
          ox = rx; oy = ry;
        end
        default: begin
          ox = rx + rand_offset(); oy = ry + rand_offset();
        end
      endcase
      px = ox;
      py = oy;
      add_item(ox, oy, rx, ry, (i == n - 1), (i != n - 1) && ($urandom_range(0, 29) == 0));
      count++;
    end
  endtask

  // Hold until the block is drained, then let it settle
  task automatic wait_idle();
    while (obstacle_q.size() != 0 || in_tvalid || standoff_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_radius(input logic [23:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    radius_now = value;
  endtask

  // Drive obstacle transactions in bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left = 0;
      gap_left = 0;
    end else if (!in_tvalid || in_tready) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (obstacle_q.size() != 0) begin
        next_item = obstacle_q.pop_front();
        in_tdata <= {4'b0, next_item.ry, next_item.rx, next_item.oy, next_item.ox};
        in_tlast <= next_item.last;
        in_tuser <= next_item.empty;
        in_tvalid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Predict on every accepted input transaction
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      track_obstacle(in_tdata[30:0], in_tdata[61:31], in_tdata[92:62], in_tdata[123:93],
                     in_tlast, in_tuser);
    end
  end

  // Stall the result side in modes that are picked again at random
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = rx_mode_t'($urandom_range(0, 3));
        stall_left = $urandom_range(16, 160);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        RX_READY:  out_tready <= 1'b1;
        RX_COIN:   out_tready <= ($urandom_range(0, 1) == 1);
        RX_SPARSE: out_tready <= ($urandom_range(0, 7) == 0);
        default:   out_tready <= stall_left[2];
      endcase
    end
  end

  // Compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (standoff_q.size() == 0) begin
        $error("result transaction with no prediction pending");
        error_count++;
      end else begin
        want = standoff_q.pop_front();
        seen.found = out_tuser;
        seen.tx = out_tdata[31:0];
        seen.ty = out_tdata[63:32];
        seen.yaw = out_tdata[80:64];
        seen.qz = out_tdata[96:81];
        seen.qw = out_tdata[112:97];
        check_field("found", longint'(want.found), longint'(seen.found));
        check_field("target_x", longint'($signed(want.tx)), longint'($signed(seen.tx)));
        check_field("target_y", longint'($signed(want.ty)), longint'($signed(seen.ty)));
        check_field("yaw", longint'($signed(want.yaw)), longint'($signed(seen.yaw)));
        check_field("quat_z", longint'($signed(want.qz)), longint'($signed(seen.qz)));
        check_field("quat_w", longint'($signed(want.qw)), longint'($signed(seen.qw)));
      end
    end
  end

  // End the run when nothing has moved for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int phase;
    int queued;
    logic [23:0] radius_pick;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed frames at the reset radius
    add_item(rand_coord(), rand_coord(), 0, 0, 1'b1, 1'b1);
    add_item(rand_coord(), rand_coord(), rand_coord(), rand_coord(), 1'b0, 1'b1);
    add_item(5 << 16, -(3 << 16), 5 << 16, -(3 << 16), 1'b1, 1'b0);
    add_item(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
    add_item(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1, 1'b0);
    add_item(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN, 1'b1, 1'b0);
    add_item(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 1'b1, 1'b0);
    // equal distances: the first centre is kept
    add_item(1 << 16, 0, 0, 0, 1'b0, 1'b0);
    add_item(-(1 << 16), 0, 0, 0, 1'b1, 1'b0);
    // nearest in the middle of the list
    add_item(10 << 16, 10 << 16, 0, 0, 1'b0, 1'b0);
    add_item(1 << 16, 2 << 16, 0, 0, 1'b0, 1'b0);
    add_item(-(20 << 16), 3 << 16, 0, 0, 1'b1, 1'b0);
    // empty transaction closes a frame that holds a centre
    add_item(3 << 16, 4 << 16, 0, 0, 1'b0, 1'b0);
    add_item(rand_coord(), rand_coord(), 0, 0, 1'b0, 1'b1);
    // heading along the axes
    add_item(-(2 << 16), 0, 0, 0, 1'b1, 1'b0);
    add_item(0, 7 << 16, 0, 0, 1'b1, 1'b0);
    add_item(0, -(7 << 16), 0, 0, 1'b1, 1'b0);
    // robot moves inside the frame; heading uses the closing position
    add_item(1 << 16, 1 << 16, 0, 0, 1'b0, 1'b0);
    add_item(50 << 16, 50 << 16, 49 << 16, 49 << 16, 1'b1, 1'b0);
    wait_idle();

    // Random phases, each under its own radius
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       radius_pick = 24'(RADIUS_MAX);
        1:       radius_pick = '0;
        3:       radius_pick = 24'd1;
        4:       radius_pick = 24'($urandom_range(1, 1 << 20));
        5:       radius_pick = 24'd65536;
        default: radius_pick = 24'($urandom_range(0, RADIUS_MAX));
      endcase
      write_radius(radius_pick);
      queued = 0;
      while (queued < ITEMS_PER_PHASE) queue_random_frame(queued);
      wait_idle();
    end

    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
